>>> rtl/core/dbbm_pkg.sv
// Shared types and constants for the dot-bracket bond matcher.
package dbbm_pkg;

    localparam int SYM_W = 8;
    localparam int POS_W = 11;

    localparam logic [SYM_W-1:0] SYM_OPEN  = 8'd40;
    localparam logic [SYM_W-1:0] SYM_CLOSE = 8'd41;

    typedef enum logic [2:0] {
        ST_BOND      = 3'd0,
        ST_END_OK    = 3'd1,
        ST_BAD_CLOSE = 3'd2,
        ST_BAD_OPEN  = 3'd3,
        ST_OVERFLOW  = 3'd4
    } status_t;

    typedef struct packed {
        logic [POS_W-1:0] open_position;
        logic [POS_W-1:0] close_from_end;
        status_t          status;
        logic             last_result;
    } result_t;

endpackage

>>> rtl/core/dot_bracket_bond_matcher.sv
// Dot-bracket bond matcher: stack of open positions in RAM, bonds out as a stream.
//
//  channel   dir  tdata (low bit up)               tuser     tlast
//  s_axis    in   symbol[7:0] string_length[18:8]  -         last_symbol
//  m_axis    out  open_position[10:0]              status    last_result
//                 close_from_end[21:11]
//
// One symbol per cycle while s_tready is high; each symbol is resolved in the cycle it is taken.
// The top of stack sits in a register, the entry below it is prefetched from the
// stack RAM into a register (forwarded when it was written the cycle before).
// A symbol that yields a bond and an end status puts two beats into a
// 4-deep result queue; s_tready drops while fewer than two slots are free.
// Reset clears counters and queue; the stack RAM needs no clearing.
module dot_bracket_bond_matcher #(
    parameter int MAX_LEN   = 1024,
    parameter int MAX_DEPTH = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // symbol[7:0], string_length[18:8], zero pad
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // open_position[10:0], close_from_end[21:11], zero pad
    output logic [2:0]  m_tuser,   // status[2:0]
    output logic        m_tlast
);
    import dbbm_pkg::*;

    localparam int CP_W  = $clog2(MAX_LEN + 2);
    localparam int EXT_W = (CP_W > POS_W) ? CP_W : POS_W;
    localparam int CNT_W = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int Q_DEPTH = 4;
    localparam int QI_W  = 2;
    localparam int QC_W  = 3;

    // stack RAM, holds every pending open except the top
    logic [POS_W-1:0] stack_mem [MAX_DEPTH];

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CP_W-1:0]  pos_reg, pos_next;
    logic             err_reg, err_next;
    logic [POS_W-1:0] top_reg, top_next;
    logic [POS_W-1:0] rd_reg;
    logic             fwd_reg;
    logic [POS_W-1:0] fwd_data_reg;

    result_t          q_mem [Q_DEPTH];
    logic [QI_W-1:0]  head_reg, tail_reg;
    logic [QC_W-1:0]  qcnt_reg;

    logic             acc, pop, last, err_now, wr_en;
    logic [SYM_W-1:0] symbol;
    logic [POS_W-1:0] str_len, pos11, close11, below;
    logic [CP_W-1:0]  pos;
    logic [EXT_W-1:0] pos_ext;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic [CNT_W-1:0] wr_cnt, rd_cnt;
    logic [1:0]       n_res;
    result_t          res0, res1, q_head;

    assign acc     = s_tvalid && s_tready;
    assign symbol  = s_tdata[SYM_W-1:0];
    assign str_len = s_tdata[SYM_W+POS_W-1:SYM_W];
    assign last    = s_tlast;
    assign pos     = pos_reg + CP_W'(1);
    assign pos_ext = EXT_W'(pos);
    assign pos11   = pos_ext[POS_W-1:0];
    assign close11 = str_len - pos11 + POS_W'(1);
    assign below   = fwd_reg ? fwd_data_reg : rd_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        pos_next = pos_reg;
        err_next = err_reg;
        top_next = top_reg;
        wr_en    = 1'b0;
        err_now  = 1'b0;
        n_res    = 2'd0;
        res0     = '{open_position: '0, close_from_end: '0, status: ST_BOND,
                     last_result: 1'b0};
        res1     = res0;
        if (acc)
        begin
            if (!err_reg)
            begin
                pos_next = (pos > CP_W'(MAX_LEN)) ? CP_W'(MAX_LEN) : pos;
                if (symbol == SYM_OPEN)
                begin
                    if (cnt_reg == CNT_W'(MAX_DEPTH))
                    begin
                        res0.status = ST_OVERFLOW;
                        n_res       = 2'd1;
                        err_now     = 1'b1;
                    end
                    else
                    begin
                        // the stack is dropped on the last symbol, no spill needed
                        wr_en    = (cnt_reg != '0) && !last;
                        top_next = pos11;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                else if (symbol == SYM_CLOSE)
                begin
                    if (cnt_reg == '0)
                    begin
                        res0.status = ST_BAD_CLOSE;
                        n_res       = 2'd1;
                        err_now     = 1'b1;
                    end
                    else
                    begin
                        res0.open_position  = top_reg;
                        res0.close_from_end = close11;
                        n_res               = 2'd1;
                        top_next            = below;
                        cnt_next            = cnt_reg - CNT_W'(1);
                    end
                end
                if (err_now)
                begin
                    err_next = 1'b1;
                end
                else if (last)
                begin
                    if (n_res == 2'd0)
                    begin
                        res0.status = (cnt_next != '0) ? ST_BAD_OPEN : ST_END_OK;
                    end
                    else
                    begin
                        res1.status = (cnt_next != '0) ? ST_BAD_OPEN : ST_END_OK;
                    end
                    n_res = n_res + 2'd1;
                end
                res0.last_result = (n_res == 2'd1);
                res1.last_result = (n_res == 2'd2);
            end
            if (last)
            begin
                cnt_next = '0;
                pos_next = '0;
                err_next = 1'b0;
            end
        end
    end

    // old top goes to RAM slot count-1; prefetch the entry under the new top
    assign wr_cnt  = cnt_reg - CNT_W'(1);
    assign rd_cnt  = cnt_next - CNT_W'(2);
    assign wr_addr = wr_cnt[IDX_W-1:0];
    assign rd_addr = rd_cnt[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= top_reg;
        end
        rd_reg       <= stack_mem[rd_addr];
        fwd_data_reg <= top_reg;
        top_reg      <= top_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            pos_reg <= '0;
            err_reg <= 1'b0;
            fwd_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            pos_reg <= pos_next;
            err_reg <= err_next;
            fwd_reg <= wr_en;
        end
    end

    // result queue
    assign s_tready = (qcnt_reg <= QC_W'(Q_DEPTH - 2));
    assign m_tvalid = (qcnt_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign q_head   = q_mem[head_reg];
    assign m_tdata  = {2'b00, q_head.close_from_end, q_head.open_position};
    assign m_tuser  = q_head.status;
    assign m_tlast  = q_head.last_result;

    always_ff @(posedge clk)
    begin
        if (n_res != 2'd0)
        begin
            q_mem[tail_reg] <= res0;
        end
        if (n_res == 2'd2)
        begin
            q_mem[tail_reg + QI_W'(1)] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            qcnt_reg <= '0;
        end
        else
        begin
            tail_reg <= tail_reg + QI_W'(n_res);
            if (pop)
            begin
                head_reg <= head_reg + QI_W'(1);
            end
            qcnt_reg <= qcnt_reg + QC_W'(n_res) - QC_W'(pop);
        end
    end

    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qcnt_reg <= QC_W'(Q_DEPTH))
        else $error("result queue overrun");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_DEPTH))
        else $error("stack count beyond depth");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        acc && s_tlast |=> cnt_reg == '0 && pos_reg == '0 && !err_reg)
        else $error("state not cleared after last symbol");

    a_fwd_depth: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> cnt_reg >= CNT_W'(2))
        else $error("forward without an entry under the top");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_BOND |-> m_tlast)
        else $error("status beat not marked last");

endmodule

>>> tb/tb.sv
// Testbench for dot_bracket_bond_matcher: random and directed strings, scoreboard check.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dbbm_pkg::*;

    localparam int MAX_LEN        = 1024;
    localparam int MAX_DEPTH      = 512;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;

    // Tracks the open stack per string and queues the bonds and statuses it implies.
    class bond_scoreboard;
        logic [POS_W-1:0] open_stack [MAX_DEPTH];
        int unsigned      depth;
        int unsigned      position;
        bit               error_seen;
        result_t          bonds_due[$];
        int               errors;

        function void add_result(ref result_t found[$], input logic [POS_W-1:0] open_pos,
                                 input logic [POS_W-1:0] close_end, input status_t st);
            result_t r;
            r.open_position  = open_pos;
            r.close_from_end = close_end;
            r.status         = st;
            r.last_result    = 1'b0;
            found = {found, r};
        endfunction

        function void note_symbol(logic [SYM_W-1:0] sym, logic [POS_W-1:0] len, bit last);
            result_t          found[$];
            int unsigned      pos;
            logic [POS_W-1:0] pos11;
            bit               err_now;
            err_now = 1'b0;
            if (!error_seen)
            begin
                pos      = position + 1;
                pos11    = pos[POS_W-1:0];
                position = (pos > MAX_LEN) ? MAX_LEN : pos;
                if (sym == SYM_OPEN)
                begin
                    if (depth >= MAX_DEPTH)
                    begin
                        add_result(found, '0, '0, ST_OVERFLOW);
                        err_now = 1'b1;
                    end
                    else
                    begin
                        open_stack[depth] = pos11;
                        depth++;
                    end
                end
                else if (sym == SYM_CLOSE)
                begin
                    if (depth == 0)
                    begin
                        add_result(found, '0, '0, ST_BAD_CLOSE);
                        err_now = 1'b1;
                    end
                    else
                    begin
                        depth--;
                        add_result(found, open_stack[depth], len - pos11 + 11'd1, ST_BOND);
                    end
                end
                if (err_now)
                    error_seen = 1'b1;
                else if (last)
                    add_result(found, '0, '0, (depth != 0) ? ST_BAD_OPEN : ST_END_OK);
            end
            if (found.size() > 0)
                found[found.size()-1].last_result = 1'b1;
            foreach (found[i])
                bonds_due = {bonds_due, found[i]};
            if (last)
            begin
                depth      = 0;
                position   = 0;
                error_seen = 1'b0;
            end
        endfunction

        function void check_bond(result_t got);
            result_t want;
            if (bonds_due.size() == 0)
            begin
                $display("%0t: unexpected beat open=%0d close=%0d status=%0d last=%0d",
                         $time, got.open_position, got.close_from_end, got.status,
                         got.last_result);
                errors++;
                return;
            end
            want = bonds_due.pop_front();
            if (got.open_position !== want.open_position)
            begin
                $display("%0t: open_position expected %0d actual %0d",
                         $time, want.open_position, got.open_position);
                errors++;
            end
            if (got.close_from_end !== want.close_from_end)
            begin
                $display("%0t: close_from_end expected %0d actual %0d",
                         $time, want.close_from_end, got.close_from_end);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.last_result !== want.last_result)
            begin
                $display("%0t: last_result expected %0d actual %0d",
                         $time, want.last_result, got.last_result);
                errors++;
            end
        endfunction

        function int pending();
            return bonds_due.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    bond_scoreboard sb;
    int tx_idle;
    int rx_idle;
    int items_sent;
    int quiet_cycles;

    dot_bracket_bond_matcher #(
        .MAX_LEN   (MAX_LEN),
        .MAX_DEPTH (MAX_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
        m_tready <= rst_n && ($urandom_range(0, 99) >= rx_idle);

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.open_position  = m_tdata[10:0];
            got.close_from_end = m_tdata[21:11];
            got.status         = status_t'(m_tuser);
            got.last_result    = m_tlast;
            sb.check_bond(got);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic logic [SYM_W-1:0] other_char();
        logic [SYM_W-1:0] c;
        do
            c = SYM_W'($urandom_range(0, 255));
        while (c == SYM_OPEN || c == SYM_CLOSE);
        return c;
    endfunction

    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic [POS_W-1:0] len,
                               input bit last);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tdata  <= {5'd0, len, sym};
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_symbol(sym, len, last);
        items_sent++;
    endtask

    task automatic send_string(input logic [SYM_W-1:0] syms[$], input logic [POS_W-1:0] len);
        foreach (syms[i])
            send_symbol(syms[i], len, i == syms.size() - 1);
    endtask

    // Hold valid low until every queued result has drained.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Mostly balanced strings; some with one symbol dropped or one bracket added; some pure noise.
    task automatic random_string();
        logic [SYM_W-1:0] syms[$];
        logic [POS_W-1:0] len;
        int kind;
        int n;
        int d;
        int pick;
        kind = $urandom_range(0, 99);
        n    = $urandom_range(1, 30);
        d    = 0;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (kind >= 85)
                syms = {syms, (pick < 30 ? SYM_OPEN : pick < 60 ? SYM_CLOSE : other_char())};
            else if (d > 0 && pick < 35)
            begin
                syms = {syms, SYM_CLOSE};
                d--;
            end
            else if (pick < 70 && d < 24)
            begin
                syms = {syms, SYM_OPEN};
                d++;
            end
            else
                syms = {syms, other_char()};
        end
        if (kind < 85)
            repeat (d) syms = {syms, SYM_CLOSE};
        if (kind >= 70 && kind < 85)
        begin
            if (syms.size() > 1 && $urandom_range(0, 1) == 1)
                syms.delete($urandom_range(0, syms.size() - 1));
            else
                syms.insert($urandom_range(0, syms.size()),
                            $urandom_range(0, 1) ? SYM_OPEN : SYM_CLOSE);
        end
        len = POS_W'(syms.size());
        if (kind >= 85 || $urandom_range(0, 9) == 0)
            len = POS_W'($urandom_range(0, 2047));
        send_string(syms, len);
    endtask

    task automatic run_random(input int tx, input int rx, input int count);
        int target;
        tx_idle = tx;
        rx_idle = rx;
        target  = items_sent + count;
        while (items_sent < target)
            random_string();
    endtask

    // Fills the stack, pops and refills from RAM, runs past MAX_LEN so the position
    // saturates, then overflows and trails ignored characters.
    task automatic deep_string();
        logic [SYM_W-1:0] syms[$];
        repeat (MAX_DEPTH) syms = {syms, SYM_OPEN};
        repeat (30) syms = {syms, SYM_CLOSE};
        repeat (30) syms = {syms, SYM_OPEN};
        repeat (454) syms = {syms, other_char()};
        syms = {syms, SYM_CLOSE};
        syms = {syms, SYM_OPEN};
        syms = {syms, SYM_OPEN};
        repeat (3) syms = {syms, other_char()};
        syms = {syms, SYM_CLOSE};
        send_string(syms, 11'd1030);
    endtask

    initial
    begin
        logic [SYM_W-1:0] syms[$];
        sb           = new;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        tx_idle      = 20;
        rx_idle      = 68;
        items_sent   = 0;
        quiet_cycles = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // one bond then a balanced end
        syms = '{SYM_OPEN, 8'd0, SYM_CLOSE};
        send_string(syms, 11'd3);
        // close with nothing open, on the last character
        syms = '{SYM_CLOSE};
        send_string(syms, 11'd1);
        // bond, then an open left over at the end
        syms = '{SYM_OPEN, SYM_OPEN, 8'd255, SYM_CLOSE};
        send_string(syms, 11'd1024);
        // characters after an error are dropped, the last one too
        syms = '{SYM_CLOSE, SYM_OPEN, 8'd46, SYM_OPEN};
        send_string(syms, 11'd4);
        // zero length: close_from_end wraps
        syms = '{SYM_OPEN, SYM_CLOSE};
        send_string(syms, 11'd0);
        // lone skipped character
        syms = '{8'd46};
        send_string(syms, 11'd1);

        run_random(20, 68, 200);
        drain();
        run_random(68, 20, 200);
        drain();
        tx_idle = 0;
        rx_idle = 0;
        deep_string();
        run_random(0, 0, 200);
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> dot_bracket_bond_matcher.f
rtl/core/dbbm_pkg.sv
rtl/core/dot_bracket_bond_matcher.sv
tb/tb.sv
